// ----- design/tpjd_pkg.sv -----
// ----------------------------------------------------------------------------
// tpjd_pkg: shared types and constants
// Sizes, queue entry layout, result layout and sequencer states of the
// typed priority job dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none
package tpjd_pkg;
  localparam int QUEUE_DEPTH   = 16;
  localparam int NUM_WORKERS   = 4;
  localparam int FINISH_DEPTH  = 32;
  localparam int DISCARD_DEPTH = 64;
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int FAW = $clog2(FINISH_DEPTH);
  localparam int DAW = $clog2(DISCARD_DEPTH);
  localparam int WAW = 2;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_WORKER = 2'd1;
  localparam logic [1:0] OP_ORDER  = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  localparam logic [1:0] KIND_WORKER = 2'd0;
  localparam logic [1:0] KIND_ORDER  = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  localparam logic [1:0] ST_PENDING   = 2'd0;
  localparam logic [1:0] ST_DISCARDED = 2'd1;
  localparam logic [1:0] ST_DOING     = 2'd2;
  localparam logic [1:0] ST_DONE      = 2'd3;

  localparam logic [2:0] REG_LIMIT = 3'd0;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pri;
    logic [15:0] dur;
    logic [7:0]  typ;
  } qent_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        busy;
    logic [1:0]  st;
    logic [15:0] id;
    logic        valid;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TW, S_MW, S_MRD, S_MEV, S_RMRD, S_RMWR, S_CMD,
    S_ADIS, S_ADISW, S_APRD, S_APEV, S_ASRD, S_ASWR, S_AINS,
    S_OQRD, S_OQEV, S_ODRD, S_ODEV, S_LRD, S_LEV, S_EMIT
  } state_t;
endpackage
`default_nettype wire

// ----- design/tpjd_ram.sv -----
// ----------------------------------------------------------------------------
// tpjd_ram: generic synchronous RAM
// One write port and one read port with registered read data that holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none
module tpjd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- design/typed_priority_job_dispatcher.sv -----
// ----------------------------------------------------------------------------
// typed_priority_job_dispatcher: bounded priority queue with typed workers
// Sequencer around a queue RAM, a finished-log RAM and a discard-log RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_ valid/ready channel; results leave on the out_
//   valid/ready channel with last marking the final result of a command.
//   Configuration (queue limit, worker types) is written through cfg_we,
//   cfg_index and cfg_data while the block is idle.
//   Each command first runs one tick: each active worker counts down in turn,
//   then each idle worker scans the queue for a job of its type, and the
//   entries behind a matched job move up when it is removed. The command
//   then runs: an add discards tail entries into the discard log until the
//   queue is below the limit, scans for its position and shifts the entries
//   behind it; an order query scans the queue and then the discard log; a
//   finished list reads its entries one by one.
//   One command is in work at a time; in_ready is high only between
//   commands, and a result held in the output register does not block the
//   next command until that command wants to emit.
//   A stalled receiver holds the sequencer at its next result.
//   Reset empties the queue, idles all workers and clears both logs; the
//   queue limit resets to 16 and worker types to 0. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module typed_priority_job_dispatcher
  import tpjd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_order_id,
  input  wire logic [15:0] in_priority_req,
  input  wire logic [15:0] in_duration,
  input  wire logic [7:0]  in_order_type,
  input  wire logic [1:0]  in_worker_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic             out_worker_busy,
  output logic [1:0]       out_order_state,
  output logic [15:0]      out_job_id,
  output logic             out_entry_valid,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  state_t      state_r, state_nxt;
  logic [4:0]  limit_r;
  logic [7:0]  wtype_r [NUM_WORKERS];
  logic [4:0]  cnt_r, cnt_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [WAW-1:0] wsel_r, wsel_nxt;
  logic        act_r [NUM_WORKERS];
  logic        act_nxt [NUM_WORKERS];
  logic [15:0] wjob_r [NUM_WORKERS];
  logic [15:0] wjob_nxt [NUM_WORKERS];
  logic [15:0] wrem_r [NUM_WORKERS];
  logic [15:0] wrem_nxt [NUM_WORKERS];
  logic [5:0]  fcnt_r [NUM_WORKERS];
  logic [5:0]  fcnt_nxt [NUM_WORKERS];
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic [1:0]  op_r;
  qent_t       cmd_r;
  logic [WAW-1:0] widx_r;
  res_t        res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  res_t        out_r, out_nxt;

  logic          q_we, q_re;
  logic [QAW-1:0] q_waddr, q_raddr;
  qent_t         q_wdata, q_rdata;
  logic          f_we, f_re;
  logic [WAW+FAW-1:0] f_waddr, f_raddr;
  logic [15:0]   f_wdata, f_rdata;
  logic          d_we, d_re;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [15:0]   d_wdata, d_rdata;

  logic [4:0]  lim;
  logic        out_free, last_w, worker_hit;
  logic [15:0] rem_dec;

  tpjd_ram #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata));
  tpjd_ram #(.WIDTH(16), .DEPTH(NUM_WORKERS * FINISH_DEPTH)) u_finished (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata));
  tpjd_ram #(.WIDTH(16), .DEPTH(DISCARD_DEPTH)) u_discard (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata));

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_r.kind;
  assign out_worker_busy = out_r.busy;
  assign out_order_state = out_r.st;
  assign out_job_id      = out_r.id;
  assign out_entry_valid = out_r.valid;
  assign out_last        = out_last_r;

  always_comb begin
    if (limit_r == 5'd0) begin
      lim = 5'd1;
    end else if (limit_r > 5'(QUEUE_DEPTH)) begin
      lim = 5'(QUEUE_DEPTH);
    end else begin
      lim = limit_r;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign last_w   = (wsel_r == WAW'(NUM_WORKERS - 1));
  assign rem_dec  = wrem_r[wsel_r] - 16'd1;

  always_comb begin
    worker_hit = 1'b0;
    for (int w = 0; w < NUM_WORKERS; w++) begin
      if (act_r[w] && wjob_r[w] == cmd_r.id) begin
        worker_hit = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    pos_nxt = pos_r;
    wsel_nxt = wsel_r;
    act_nxt = act_r;
    wjob_nxt = wjob_r;
    wrem_nxt = wrem_r;
    fcnt_nxt = fcnt_r;
    dcnt_nxt = dcnt_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    out_last_nxt = out_last_r;
    q_we = 1'b0; q_re = 1'b0;
    q_waddr = idx_r[QAW-1:0]; q_raddr = idx_r[QAW-1:0];
    q_wdata = q_rdata;
    f_we = 1'b0; f_re = 1'b0;
    f_waddr = {wsel_r, fcnt_r[wsel_r][FAW-1:0]};
    f_raddr = {widx_r, idx_r[FAW-1:0]};
    f_wdata = wjob_r[wsel_r];
    d_we = 1'b0; d_re = 1'b0;
    d_waddr = dcnt_r[DAW-1:0]; d_raddr = idx_r[DAW-1:0];
    d_wdata = q_rdata.id;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wsel_nxt = '0;
          state_nxt = S_TW;
        end
      end
      S_TW: begin
        if (act_r[wsel_r]) begin
          wrem_nxt[wsel_r] = rem_dec;
          if (rem_dec == 16'd0) begin
            act_nxt[wsel_r] = 1'b0;
            if (fcnt_r[wsel_r] < 6'(FINISH_DEPTH)) begin
              f_we = 1'b1;
              fcnt_nxt[wsel_r] = fcnt_r[wsel_r] + 6'd1;
            end
          end
        end
        if (last_w) begin
          wsel_nxt = '0;
          state_nxt = S_MW;
        end else begin
          wsel_nxt = wsel_r + WAW'(1);
        end
      end
      S_MW: begin
        if (act_r[wsel_r]) begin
          if (last_w) state_nxt = S_CMD;
          else wsel_nxt = wsel_r + WAW'(1);
        end else begin
          idx_nxt = '0;
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        if (idx_r < {2'b00, cnt_r}) begin
          q_re = 1'b1;
          state_nxt = S_MEV;
        end else if (last_w) begin
          state_nxt = S_CMD;
        end else begin
          wsel_nxt = wsel_r + WAW'(1);
          state_nxt = S_MW;
        end
      end
      S_MEV: begin
        if (q_rdata.typ == wtype_r[wsel_r]) begin
          act_nxt[wsel_r] = 1'b1;
          wjob_nxt[wsel_r] = q_rdata.id;
          wrem_nxt[wsel_r] = q_rdata.dur;
          state_nxt = S_RMRD;
        end else begin
          idx_nxt = idx_r + 7'd1;
          state_nxt = S_MRD;
        end
      end
      S_RMRD: begin
        if ((idx_r + 7'd1) < {2'b00, cnt_r}) begin
          q_re = 1'b1;
          q_raddr = QAW'(idx_r + 7'd1);
          state_nxt = S_RMWR;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
          if (last_w) begin
            state_nxt = S_CMD;
          end else begin
            wsel_nxt = wsel_r + WAW'(1);
            state_nxt = S_MW;
          end
        end
      end
      S_RMWR: begin
        q_we = 1'b1;
        idx_nxt = idx_r + 7'd1;
        state_nxt = S_RMRD;
      end
      S_CMD: begin
        idx_nxt = '0;
        case (op_r)
          OP_ADD:   state_nxt = S_ADIS;
          OP_ORDER: state_nxt = S_OQRD;
          OP_WORKER: begin
            res_nxt.kind = KIND_WORKER;
            res_nxt.busy = act_r[widx_r];
            res_nxt.st = ST_PENDING;
            res_nxt.id = act_r[widx_r] ? wjob_r[widx_r] : 16'd0;
            res_nxt.valid = 1'b0;
            state_nxt = S_EMIT;
          end
          default: begin
            if (fcnt_r[widx_r] == 6'd0) begin
              res_nxt.kind = KIND_LIST;
              res_nxt.busy = 1'b0;
              res_nxt.st = ST_PENDING;
              res_nxt.id = 16'd0;
              res_nxt.valid = 1'b0;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_LRD;
            end
          end
        endcase
      end
      S_ADIS: begin
        if (cnt_r >= lim) begin
          q_re = 1'b1;
          q_raddr = QAW'(cnt_r - 5'd1);
          state_nxt = S_ADISW;
        end else begin
          state_nxt = S_APRD;
        end
      end
      S_ADISW: begin
        if (dcnt_r < 7'(DISCARD_DEPTH)) begin
          d_we = 1'b1;
          dcnt_nxt = dcnt_r + 7'd1;
        end
        cnt_nxt = cnt_r - 5'd1;
        state_nxt = S_ADIS;
      end
      S_APRD: begin
        if (idx_r < {2'b00, cnt_r}) begin
          q_re = 1'b1;
          state_nxt = S_APEV;
        end else begin
          pos_nxt = cnt_r;
          idx_nxt = {2'b00, cnt_r};
          state_nxt = S_ASRD;
        end
      end
      S_APEV: begin
        if (cmd_r.pri >= q_rdata.pri) begin
          pos_nxt = idx_r[4:0];
          idx_nxt = {2'b00, cnt_r};
          state_nxt = S_ASRD;
        end else begin
          idx_nxt = idx_r + 7'd1;
          state_nxt = S_APRD;
        end
      end
      S_ASRD: begin
        if (idx_r > {2'b00, pos_r}) begin
          q_re = 1'b1;
          q_raddr = QAW'(idx_r - 7'd1);
          state_nxt = S_ASWR;
        end else begin
          state_nxt = S_AINS;
        end
      end
      S_ASWR: begin
        // Moves one entry up a slot; the discard step has already made room, so none falls off.
        q_we = 1'b1;
        idx_nxt = idx_r - 7'd1;
        state_nxt = S_ASRD;
      end
      S_AINS: begin
        q_we = 1'b1;
        q_waddr = pos_r[QAW-1:0];
        q_wdata = cmd_r;
        cnt_nxt = cnt_r + 5'd1;
        state_nxt = S_IDLE;
      end
      S_OQRD: begin
        res_nxt.kind = KIND_ORDER;
        res_nxt.busy = 1'b0;
        res_nxt.id = cmd_r.id;
        res_nxt.valid = 1'b0;
        if (idx_r < {2'b00, cnt_r}) begin
          q_re = 1'b1;
          state_nxt = S_OQEV;
        end else begin
          idx_nxt = '0;
          state_nxt = S_ODRD;
        end
      end
      S_OQEV: begin
        if (q_rdata.id == cmd_r.id) begin
          res_nxt.st = ST_PENDING;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + 7'd1;
          state_nxt = S_OQRD;
        end
      end
      S_ODRD: begin
        if (idx_r < dcnt_r) begin
          d_re = 1'b1;
          state_nxt = S_ODEV;
        end else begin
          res_nxt.st = worker_hit ? ST_DOING : ST_DONE;
          state_nxt = S_EMIT;
        end
      end
      S_ODEV: begin
        if (d_rdata == cmd_r.id) begin
          res_nxt.st = ST_DISCARDED;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + 7'd1;
          state_nxt = S_ODRD;
        end
      end
      S_LRD: begin
        f_re = 1'b1;
        state_nxt = S_LEV;
      end
      S_LEV: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind = KIND_LIST;
          out_nxt.busy = 1'b0;
          out_nxt.st = ST_PENDING;
          out_nxt.id = f_rdata;
          out_nxt.valid = 1'b1;
          out_last_nxt = ((idx_r + 7'd1) == {1'b0, fcnt_r[widx_r]});
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 7'd1;
            state_nxt = S_LRD;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = res_r;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= 5'd16;
      cnt_r <= '0;
      dcnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int w = 0; w < NUM_WORKERS; w++) begin
        wtype_r[w] <= '0;
        act_r[w] <= 1'b0;
        fcnt_r[w] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      dcnt_r <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      act_r <= act_nxt;
      fcnt_r <= fcnt_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_LIMIT) begin
          limit_r <= cfg_data[4:0];
        end else if (cfg_index <= 3'(NUM_WORKERS)) begin
          wtype_r[WAW'(cfg_index - 3'd1)] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    wsel_r <= wsel_nxt;
    wjob_r <= wjob_nxt;
    wrem_r <= wrem_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    out_last_r <= out_last_nxt;
    if (state_r == S_IDLE && in_valid) begin
      op_r <= in_opcode;
      cmd_r <= '{id: in_order_id, pri: in_priority_req, dur: in_duration,
                 typ: in_order_type};
      widx_r <= in_worker_index;
    end
  end
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the typed priority job dispatcher
// Sends add and query commands through the input handshake, predicts the
// results with a behavioral copy of the queue, the workers and both logs, and
// compares every result transaction field by field against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench
  import tpjd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_MAX = 32;

  typedef struct {
    logic [1:0]  kind;
    logic        busy;
    logic [1:0]  st;
    logic [15:0] id;
    logic        valid;
    logic        last;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_opcode = OP_ADD;
  logic [15:0] in_order_id = '0;
  logic [15:0] in_priority_req = '0;
  logic [15:0] in_duration = 16'd1;
  logic [7:0]  in_order_type = '0;
  logic [1:0]  in_worker_index = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire [1:0]   out_result_kind;
  wire         out_worker_busy;
  wire [1:0]   out_order_state;
  wire [15:0]  out_job_id;
  wire         out_entry_valid;
  wire         out_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  typed_priority_job_dispatcher dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the dispatcher.
  int unsigned m_limit;
  logic [7:0]  m_wtype[NUM_WORKERS];
  qent_t       m_queue[$];
  logic        m_busy[NUM_WORKERS];
  logic [15:0] m_wjob[NUM_WORKERS];
  logic [15:0] m_wleft[NUM_WORKERS];
  logic [15:0] m_done[NUM_WORKERS][$];
  logic [15:0] m_dropped[$];

  answer_t     pending_answers[$];
  int          errors = 0;
  int          hold_cycles = 0;
  logic [15:0] next_id = 16'd1;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic advance_workers();
    for (int w = 0; w < NUM_WORKERS; w++) begin
      if (m_busy[w]) begin
        m_wleft[w] = m_wleft[w] - 16'd1;
        if (m_wleft[w] == 16'd0) begin
          if (m_done[w].size() < FINISH_DEPTH) m_done[w].push_back(m_wjob[w]);
          m_busy[w] = 1'b0;
        end
      end
    end
    for (int w = 0; w < NUM_WORKERS; w++) begin
      if (!m_busy[w]) begin
        for (int i = 0; i < m_queue.size(); i++) begin
          if (m_queue[i].typ == m_wtype[w]) begin
            m_busy[w] = 1'b1;
            m_wjob[w] = m_queue[i].id;
            m_wleft[w] = m_queue[i].dur;
            m_queue.delete(i);
            break;
          end
        end
      end
    end
  endtask

  function automatic logic [1:0] order_lookup(input logic [15:0] id);
    foreach (m_queue[i]) if (m_queue[i].id == id) return ST_PENDING;
    foreach (m_dropped[i]) if (m_dropped[i] == id) return ST_DISCARDED;
    for (int w = 0; w < NUM_WORKERS; w++)
      if (m_busy[w] && m_wjob[w] == id) return ST_DOING;
    return ST_DONE;
  endfunction

  task automatic predict_command(input logic [1:0] op, input logic [15:0] id,
                                 input logic [15:0] pri, input logic [15:0] dur,
                                 input logic [7:0] typ, input logic [1:0] w);
    answer_t a;
    int unsigned lim;
    int pos, n;
    qent_t e;
    advance_workers();
    a = '{kind: KIND_WORKER, busy: 1'b0, st: ST_PENDING, id: '0, valid: 1'b0,
          last: 1'b1};
    case (op)
      OP_ADD: begin
        lim = (m_limit < 1) ? 1 : (m_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : m_limit;
        while (m_queue.size() >= lim) begin
          if (m_dropped.size() < DISCARD_DEPTH) m_dropped.push_back(m_queue[$].id);
          void'(m_queue.pop_back());
        end
        pos = m_queue.size();
        foreach (m_queue[i]) if (pri >= m_queue[i].pri) begin
          pos = i;
          break;
        end
        e = '{id: id, pri: pri, dur: dur, typ: typ};
        m_queue.insert(pos, e);
      end
      OP_ORDER: begin
        a.kind = KIND_ORDER;
        a.st = order_lookup(id);
        a.id = id;
        pending_answers.push_back(a);
      end
      OP_WORKER: begin
        a.busy = m_busy[w];
        a.id = m_busy[w] ? m_wjob[w] : 16'd0;
        pending_answers.push_back(a);
      end
      default: begin
        a.kind = KIND_LIST;
        n = m_done[w].size();
        if (n > LIST_MAX) n = LIST_MAX;
        if (n == 0) pending_answers.push_back(a);
        for (int k = 0; k < n; k++) begin
          a.id = m_done[w][k];
          a.valid = 1'b1;
          a.last = (k == n - 1);
          pending_answers.push_back(a);
        end
      end
    endcase
  endtask

  // Sends one command; the prediction is made when the transaction is accepted.
  task automatic send_command(input logic [1:0] op, input logic [15:0] id,
                              input logic [15:0] pri, input logic [15:0] dur,
                              input logic [7:0] typ, input logic [1:0] w);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_order_id <= id;
    in_priority_req <= pri;
    in_duration <= dur;
    in_order_type <= typ;
    in_worker_index <= w;
    do @(posedge clk); while (!in_ready);
    predict_command(op, id, pri, dur, typ, w);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LIMIT) m_limit = val[4:0];
    else m_wtype[idx - 1] = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk);
    // An add leaves no result, so let any command still in work finish.
    idle_gap(600);
  endtask

  task automatic add_job(input logic [15:0] pri, input logic [15:0] dur,
                         input logic [7:0] typ);
    send_command(OP_ADD, next_id, pri, dur, typ, 2'd0);
    next_id++;
  endtask

  task automatic random_command(input logic [7:0] tmax);
    int sel;
    logic [15:0] qid;
    sel = $urandom_range(0, 9);
    qid = ($urandom_range(0, 3) == 0) ? 16'($urandom) : next_id - 16'($urandom_range(1, 40));
    if (sel < 5)
      add_job(16'($urandom), ($urandom_range(0, 9) == 0) ? 16'($urandom)
              : 16'($urandom_range(1, 12)), 8'($urandom_range(0, tmax)));
    else if (sel < 7) send_command(OP_ORDER, qid, 16'($urandom), 16'($urandom), 8'($urandom),
                                   2'($urandom));
    else if (sel < 8) send_command(OP_WORKER, 16'($urandom), 16'($urandom), 16'($urandom),
                                   8'($urandom), 2'($urandom));
    else send_command(OP_LIST, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                      2'($urandom));
  endtask

  task automatic test_directed();
    send_command(OP_LIST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3);
    send_command(OP_WORKER, 16'h0, 16'h0, 16'h0, 8'h0, 2'd0);
    send_command(OP_ORDER, 16'hFFFF, 16'h0, 16'h0, 8'h0, 2'd1);
    wait_drained();
    write_reg(3'd1, 8'd5);
    write_reg(3'd2, 8'hFF);
    write_reg(3'd3, 8'd7);
    write_reg(3'd4, 8'd7);
    add_job(16'd10, 16'd3, 8'd9);
    add_job(16'd10, 16'd2, 8'd9);
    add_job(16'hFFFF, 16'hFFFF, 8'd9);
    add_job(16'd0, 16'd1, 8'd9);
    send_command(OP_ORDER, next_id - 16'd2, 16'd0, 16'd0, 8'd0, 2'd0);
    add_job(16'd5, 16'd2, 8'hFF);
    add_job(16'd5, 16'd1, 8'd5);
    // Zero duration keeps worker 2 busy for a very long time.
    send_command(OP_ADD, 16'hFFFF, 16'd1, 16'd0, 8'd7, 2'd3);
    add_job(16'd1, 16'd1, 8'd7);
    send_command(OP_WORKER, 16'd0, 16'd0, 16'd0, 8'd0, 2'd2);
    send_command(OP_ORDER, 16'hFFFF, 16'd0, 16'd0, 8'd0, 2'd0);
    for (int w = 0; w < NUM_WORKERS; w++)
      send_command(OP_LIST, 16'd0, 16'd0, 16'd0, 8'd0, 2'(w));
    wait_drained();
    // Lowering the limit below the queue size drops several entries at once.
    write_reg(REG_LIMIT, 8'd1);
    add_job(16'd20, 16'd1, 8'd9);
    send_command(OP_ORDER, next_id - 16'd4, 16'd0, 16'd0, 8'd0, 2'd0);
    wait_drained();
  endtask

  task automatic test_random(input int count, input logic [7:0] tmax);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        random_command(tmax);
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int k = 0; k < 20; k++)
      send_command(k[0] ? OP_ORDER : OP_LIST, next_id - 16'd1, 16'd0, 16'd0, 8'd0,
                   2'(k));
    wait_drained();
  endtask

  task automatic test_full_logs();
    write_reg(REG_LIMIT, 8'd0);
    for (int w = 0; w < NUM_WORKERS; w++) write_reg(3'(w + 1), 8'(w));
    // Short jobs of types 0 to 4 feed the finished logs; no worker takes type 4.
    for (int k = 0; k < 90; k++) begin
      add_job(16'($urandom), 16'd1, 8'($urandom_range(0, 4)));
      if (k % 15 == 14)
        send_command(OP_LIST, 16'd0, 16'd0, 16'd0, 8'd0, 2'($urandom_range(0, 3)));
    end
    for (int w = 0; w < NUM_WORKERS; w++)
      send_command(OP_LIST, 16'd0, 16'd0, 16'd0, 8'd0, 2'(w));
    wait_drained();
  endtask

  // Checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", out_job_id, 16'd0);
      end else begin
        a = pending_answers.pop_front();
        if (out_result_kind !== a.kind) report_mismatch("kind", out_result_kind, a.kind);
        if (out_worker_busy !== a.busy) report_mismatch("busy", out_worker_busy, a.busy);
        if (out_order_state !== a.st) report_mismatch("state", out_order_state, a.st);
        if (out_job_id !== a.id) report_mismatch("job_id", out_job_id, a.id);
        if (out_entry_valid !== a.valid) report_mismatch("valid", out_entry_valid, a.valid);
        if (out_last !== a.last) report_mismatch("last", out_last, a.last);
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($time / 2000) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    m_limit = 16;
    foreach (m_busy[w]) begin
      m_busy[w] = 1'b0;
      m_wtype[w] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_reg(REG_LIMIT, 8'd16);
    test_random(40, 8'd3);
    test_backpressure();
    write_reg(REG_LIMIT, 8'd31);
    write_reg(3'd1, 8'd1);
    write_reg(3'd4, 8'd2);
    test_random(40, 8'd3);
    write_reg(REG_LIMIT, 8'd3);
    test_random(30, 8'd3);
    test_full_logs();
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
design/tpjd_pkg.sv
design/tpjd_ram.sv
design/typed_priority_job_dispatcher.sv
bench/testbench.sv
